@@ rtl/core/ppn_pkg.sv @@
// Shared types and constants of the pedal plausibility normalizer.
package ppn_pkg;

    // Default widths
    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 15;
    localparam int CMD_BITS          = 16;

    // Window margins in ADC codes
    localparam int ACC1_MARGIN  = 20;
    localparam int ACC2_MARGIN  = 50;
    localparam int BRAKE_MARGIN = 20;

    // Calibration register map
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;
    localparam int REG_RESET_END = 4095;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ACC1_START  = 3'd0,
        REG_ACC1_END    = 3'd1,
        REG_ACC2_START  = 3'd2,
        REG_ACC2_END    = 3'd3,
        REG_BRAKE_START = 3'd4,
        REG_BRAKE_END   = 3'd5
    } reg_idx_t;

    // Fault cause codes
    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_RANGE    = 2'd1,
        CAUSE_MISMATCH = 2'd2,
        CAUSE_LATCHED  = 2'd3
    } cause_t;

    // Window flags one lane reports to the merge stage
    typedef struct packed {
        logic below_lo;     // sample under min(start,end) - margin
        logic above_hi;     // sample over max(start,end) + margin
        logic under_start;  // sample under start - margin
    } lane_flags_t;

endpackage

@@ rtl/core/ppn_lane.sv @@
// One normalization lane: window checks and a radix-2 restoring divider.
module ppn_lane import ppn_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int MARGIN        = ACC1_MARGIN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [SAMPLE_BITS-1:0]        raw,
    input  logic [SAMPLE_BITS-1:0]        cal_start,
    input  logic [SAMPLE_BITS-1:0]        cal_end,
    output logic                          done,
    output logic signed [FRACTION_BITS+2:0] q,
    output lane_flags_t                   flags
);

    localparam int S    = SAMPLE_BITS;
    localparam int F    = FRACTION_BITS;
    localparam int STEPS = F + 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    localparam logic signed [S+1:0] MARGIN_W = (S+2)'(MARGIN);
    localparam logic [F+1:0]        TWO_MAG  = (F+2)'(1) << (F + 1);
    localparam logic [F+2:0]        ONE_Q    = (F+3)'(1) << F;

    // Setup arithmetic on the incoming request
    logic signed [S+1:0] raw_s, st_s, en_s, num_s, den_s, lo_s, hi_s;
    logic [S-1:0]        num_abs, den_abs;
    logic [S+1:0]        num_abs_w, den_x4;

    always_comb begin
        raw_s     = signed'({2'b00, raw});
        st_s      = signed'({2'b00, cal_start});
        en_s      = signed'({2'b00, cal_end});
        num_s     = raw_s - st_s;
        den_s     = en_s - st_s;
        num_abs   = num_s[S+1] ? S'(-num_s) : num_s[S-1:0];
        den_abs   = den_s[S+1] ? S'(-den_s) : den_s[S-1:0];
        num_abs_w = {2'b00, num_abs};
        den_x4    = {den_abs, 2'b00};
        lo_s      = ((st_s < en_s) ? st_s : en_s) - MARGIN_W;
        hi_s      = ((st_s < en_s) ? en_s : st_s) + MARGIN_W;
    end

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [S:0]        rem_reg, rem_next;
    logic [F+1:0]      feed_reg, feed_next;
    logic [F+1:0]      quo_reg, quo_next;
    logic [S-1:0]      den_reg;
    logic              neg_reg, zero_reg, ovf_reg;
    lane_flags_t       flags_reg;

    // One quotient bit per cycle
    logic [S:0] shifted;
    logic       fits;

    always_comb begin
        shifted   = {rem_reg[S-1:0], feed_reg[F+1]};
        fits      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        feed_next = feed_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            rem_next  = (S+1)'(num_abs >> 2);
            feed_next = {num_abs[1:0], {F{1'b0}}};
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? (shifted - {1'b0, den_reg}) : shifted;
            feed_next = {feed_reg[F:0], 1'b0};
            quo_next  = {quo_reg[F:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        feed_reg <= feed_next;
        quo_reg  <= quo_next;
        if (start) begin
            den_reg               <= den_abs;
            neg_reg               <= num_s[S+1] ^ den_s[S+1];
            zero_reg              <= (den_abs == '0);
            ovf_reg               <= (num_abs_w >= den_x4);
            flags_reg.below_lo    <= raw_s < lo_s;
            flags_reg.above_hi    <= raw_s > hi_s;
            flags_reg.under_start <= raw_s < (st_s - MARGIN_W);
        end
    end

    // Saturate to two, apply sign, zero span reads full scale
    logic [F+1:0] mag;
    logic [F+2:0] mag_w;

    always_comb begin
        mag   = (ovf_reg || (quo_reg > TWO_MAG)) ? TWO_MAG : quo_reg;
        mag_w = {1'b0, mag};
        if (zero_reg) begin
            q = signed'(ONE_Q);
        end else if (neg_reg) begin
            q = signed'(-mag_w);
        end else begin
            q = signed'(mag_w);
        end
    end

    assign done  = ~busy_reg;
    assign flags = flags_reg;

endmodule

@@ rtl/core/ppn_merge.sv @@
// Merge stage: plausibility decisions, latch, clamps and result register.
module ppn_merge import ppn_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic signed [FRACTION_BITS+2:0] q_acc1,
    input  logic signed [FRACTION_BITS+2:0] q_acc2,
    input  logic signed [FRACTION_BITS+2:0] q_brake,
    input  lane_flags_t                     flags_acc1,
    input  lane_flags_t                     flags_acc2,
    input  lane_flags_t                     flags_brake,
    output logic [CMD_BITS-1:0]             accel_command,
    output logic [CMD_BITS-1:0]             brake_command,
    output logic                            implausible,
    output cause_t                          fault_cause
);

    localparam int F       = FRACTION_BITS;
    localparam int ONE_I   = 1 << F;
    localparam int TENTH_I = (ONE_I + 5) / 10;
    localparam int FIFTH_I = (2 * ONE_I + 5) / 10;
    localparam int TWENT_I = (ONE_I + 10) / 20;

    localparam logic signed [F+3:0] ONE_W   = (F+4)'(ONE_I);
    localparam logic signed [F+3:0] TENTH_W = (F+4)'(TENTH_I);
    localparam logic signed [F+3:0] FIFTH_W = (F+4)'(FIFTH_I);
    localparam logic signed [F+3:0] TWENT_W = (F+4)'(TWENT_I);
    localparam logic [F:0]          TENTH_U = (F+1)'(TENTH_I);

    logic          latch_reg, latch_next;
    logic [F:0]    prev_reg, prev_next;
    logic [F:0]    accel_reg, brake_reg;
    cause_t        cause_reg, cause_next;

    logic signed [F+3:0] q1_w, q2_w, qb_w, b_w, sum_w, diff_w, adiff_w, mean_w, acc_w;
    logic [F:0]          b_val, acc_val;
    logic                range_bad, latch_t;

    // Decision logic
    always_comb begin
        q1_w    = {q_acc1[F+2], q_acc1};
        q2_w    = {q_acc2[F+2], q_acc2};
        qb_w    = {q_brake[F+2], q_brake};

        // brake: clamp to one, deadband, below-start cut
        b_w = (qb_w > ONE_W) ? ONE_W : qb_w;
        if (b_w < TWENT_W || flags_brake.under_start) begin
            b_w = '0;
        end
        b_val = b_w[F:0];

        sum_w   = q1_w + q2_w;
        diff_w  = q1_w - q2_w;
        adiff_w = diff_w[F+3] ? -diff_w : diff_w;
        mean_w  = signed'(sum_w + (F+4)'(sum_w[F+3])) >>> 1;
        acc_w   = (mean_w > ONE_W) ? ONE_W : mean_w;

        range_bad = flags_acc1.below_lo | flags_acc1.above_hi
                  | flags_acc2.below_lo | flags_acc2.above_hi;

        latch_next = latch_reg;
        cause_next = CAUSE_NONE;
        acc_val    = '0;
        latch_t    = latch_reg;
        if (range_bad) begin
            latch_next = 1'b1;
            cause_next = CAUSE_RANGE;
        end else if (adiff_w > TENTH_W) begin
            latch_next = 1'b1;
            cause_next = CAUSE_MISMATCH;
        end else begin
            if (b_w > FIFTH_W && prev_reg > TENTH_U) begin
                latch_t = 1'b1;
            end
            if (mean_w < TWENT_W) begin
                latch_t = 1'b0;
            end
            latch_next = latch_t;
            if (!latch_t) begin
                acc_val = (acc_w < TWENT_W) ? '0 : acc_w[F:0];
            end else begin
                cause_next = CAUSE_LATCHED;
            end
        end
        prev_next = acc_val;
    end

    // State updates once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= 1'b0;
            prev_reg  <= '0;
        end else if (load) begin
            latch_reg <= latch_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            accel_reg <= acc_val;
            brake_reg <= b_val;
            cause_reg <= cause_next;
        end
    end

    // Result fields at command width
    logic [F+CMD_BITS:0] accel_ext, brake_ext;

    always_comb begin
        accel_ext = {{CMD_BITS{1'b0}}, accel_reg};
        brake_ext = {{CMD_BITS{1'b0}}, brake_reg};
    end

    assign accel_command = accel_ext[CMD_BITS-1:0];
    assign brake_command = brake_ext[CMD_BITS-1:0];
    assign implausible   = (cause_reg != CAUSE_NONE);
    assign fault_cause   = cause_reg;

endmodule

@@ rtl/core/pedal_plausibility_normalizer.sv @@
// Top level of the pedal plausibility normalizer: three lanes, merge stage, control.
//
//  Channel   Ports              Payload (low bits first)
//  input     s_axis_t*          acc1_sample, acc2_sample, brake_sample
//  result    m_axis_t*          tdata: accel_command, brake_command;
//                               tuser: implausible, fault_cause
//  config    cfg_wr_*           register index, calibration code
//
// A request runs through the restoring dividers in the three lanes, which make
// one quotient bit a cycle, FRACTION_BITS + 2 bits; then, once the result
// register is free, the merge stage loads it.
// Reset (aresetn low, synchronous) clears the latch, the previous demand and
// all valid flags; calibration returns to start 0, end all ones.
// A stalled result blocks the next load, never the lanes already running.
module pedal_plausibility_normalizer import ppn_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // acc1_sample, acc2_sample, brake_sample, zero fill to bytes
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // accel_command, brake_command
    output logic [2*CMD_BITS-1:0] m_axis_tdata,
    // implausible, fault_cause
    output logic [2:0]           m_axis_tuser,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_wr_data
);

    localparam int S = SAMPLE_BITS;
    localparam int F = FRACTION_BITS;
    localparam logic [S-1:0] END_RESET = S'(REG_RESET_END);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    // Calibration registers
    logic [S-1:0] cal_reg [NUM_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg[REG_ACC1_START]  <= '0;
            cal_reg[REG_ACC1_END]    <= END_RESET;
            cal_reg[REG_ACC2_START]  <= '0;
            cal_reg[REG_ACC2_END]    <= END_RESET;
            cal_reg[REG_BRAKE_START] <= '0;
            cal_reg[REG_BRAKE_END]   <= END_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ACC1_START:  cal_reg[REG_ACC1_START]  <= cfg_wr_data;
                REG_ACC1_END:    cal_reg[REG_ACC1_END]    <= cfg_wr_data;
                REG_ACC2_START:  cal_reg[REG_ACC2_START]  <= cfg_wr_data;
                REG_ACC2_END:    cal_reg[REG_ACC2_END]    <= cfg_wr_data;
                REG_BRAKE_START: cal_reg[REG_BRAKE_START] <= cfg_wr_data;
                REG_BRAKE_END:   cal_reg[REG_BRAKE_END]   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Control
    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept, load, lanes_done, out_free;
    logic   done1, done2, doneb;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign lanes_done    = done1 & done2 & doneb;
    assign out_free      = ~m_valid_reg | m_axis_tready;
    assign load          = (state_reg == ST_BUSY) & lanes_done & out_free;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (load) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Lanes
    logic signed [F+2:0] q1, q2, qb;
    lane_flags_t         fl1, fl2, flb;

    ppn_lane #(
        .SAMPLE_BITS(S), .FRACTION_BITS(F), .MARGIN(ACC1_MARGIN)
    ) u_lane_acc1 (
        .aclk(aclk), .aresetn(aresetn), .start(accept),
        .raw(s_axis_tdata[S-1:0]),
        .cal_start(cal_reg[REG_ACC1_START]), .cal_end(cal_reg[REG_ACC1_END]),
        .done(done1), .q(q1), .flags(fl1)
    );

    ppn_lane #(
        .SAMPLE_BITS(S), .FRACTION_BITS(F), .MARGIN(ACC2_MARGIN)
    ) u_lane_acc2 (
        .aclk(aclk), .aresetn(aresetn), .start(accept),
        .raw(s_axis_tdata[2*S-1:S]),
        .cal_start(cal_reg[REG_ACC2_START]), .cal_end(cal_reg[REG_ACC2_END]),
        .done(done2), .q(q2), .flags(fl2)
    );

    ppn_lane #(
        .SAMPLE_BITS(S), .FRACTION_BITS(F), .MARGIN(BRAKE_MARGIN)
    ) u_lane_brake (
        .aclk(aclk), .aresetn(aresetn), .start(accept),
        .raw(s_axis_tdata[3*S-1:2*S]),
        .cal_start(cal_reg[REG_BRAKE_START]), .cal_end(cal_reg[REG_BRAKE_END]),
        .done(doneb), .q(qb), .flags(flb)
    );

    // Merge
    logic [CMD_BITS-1:0] accel_cmd, brake_cmd;
    logic                implausible;
    cause_t              cause;

    ppn_merge #(
        .FRACTION_BITS(F)
    ) u_merge (
        .aclk(aclk), .aresetn(aresetn), .load(load),
        .q_acc1(q1), .q_acc2(q2), .q_brake(qb),
        .flags_acc1(fl1), .flags_acc2(fl2), .flags_brake(flb),
        .accel_command(accel_cmd), .brake_command(brake_cmd),
        .implausible(implausible), .fault_cause(cause)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {brake_cmd, accel_cmd};
    assign m_axis_tuser  = {cause, implausible};

`ifndef ASSERT_OFF
    // A fault always forces the accelerator demand to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && implausible |-> accel_cmd == '0)
        else $error("accel demand nonzero under fault");

    // The fault flag agrees with the cause code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> implausible == (cause != CAUSE_NONE))
        else $error("fault flag and cause disagree");

    // A result is loaded only from finished lanes into a free register
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> lanes_done && out_free)
        else $error("result loaded early");

    // An accepted request closes the input until its result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_axis_tready && !lanes_done)
        else $error("input reopened while lanes busy");
`endif

endmodule
